[rtl/dead_reckoning_pose_tracker_macros.svh]
// Assertion macros shared by the pose tracker RTL.
// Depends on nothing; included by the files that carry checks.
`ifndef DEAD_RECKONING_POSE_TRACKER_MACROS_SVH
`define DEAD_RECKONING_POSE_TRACKER_MACROS_SVH

// Condition holds at every clock edge outside reset
`define DRPT_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define DRPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define DRPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/drpt_pkg.sv]
// Shared types, constants, sine table and helpers for the pose tracker.
// Depends on nothing; imported by every module of the block but drpt_ram.
package drpt_pkg;

   // Default sizes
   localparam int POS_BITS_DEF  = 16;
   localparam int DIST_BITS_DEF = 12;
   localparam int SINE_FRAC_DEF = 15;

   // Fixed field widths
   localparam int FUNC_W  = 2;
   localparam int ANGLE_W = 9;
   localparam int QUAD_W  = 3;

   // Fraction bits of the stored sine table
   localparam int ROM_FRAC_BITS = 15;
   localparam int ROM_W         = 16;
   localparam int ROM_IDX_W     = 7;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_MOVE     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TURN_CW  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TURN_CCW = 2'd2;

   // Quadrant codes
   localparam logic [QUAD_W-1:0] QUAD_1 = 3'd1;
   localparam logic [QUAD_W-1:0] QUAD_2 = 3'd2;
   localparam logic [QUAD_W-1:0] QUAD_3 = 3'd3;
   localparam logic [QUAD_W-1:0] QUAD_4 = 3'd4;

   // Angle constants in degrees
   localparam logic [ANGLE_W-1:0] RIGHT_ANGLE   = 9'd90;
   localparam logic [ANGLE_W-1:0] HALF_TURN     = 9'd180;
   localparam logic [ANGLE_W-1:0] THREE_QUARTER = 9'd270;
   localparam logic [ANGLE_W-1:0] FULL_TURN     = 9'd360;

   // Heading part of the pose, heading in the lowest bits
   typedef struct packed {
      logic [QUAD_W-1:0]  quadrant;
      logic [ANGLE_W-1:0] prev_heading;
      logic [ANGLE_W-1:0] heading;
   } head_type;

   // Per-item move control from the fold stage to the accumulator
   typedef struct packed {
      logic move;
      logic neg_x;
      logic neg_y;
   } step_type;

   // Heading of an item in flight, for forwarding
   typedef struct packed {
      logic     valid;
      head_type head;
   } fwd_type;

   // round(sin(k deg) * 2^15), k = 0..90
   localparam logic [ROM_W-1:0] SINE_Q15 [0:90] = '{
      16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
      16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
      16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
      16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
      16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
      16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
      16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
      16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
      16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
      16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
      16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
   };

   // Table read, indexes past 90 deg clamp to the last entry
   function automatic logic [ROM_W-1:0] sine_q15(input logic [ROM_IDX_W-1:0] idx);
      logic [ROM_W-1:0] val;
      if (idx > ROM_IDX_W'(RIGHT_ANGLE)) val = SINE_Q15[90];
      else                               val = SINE_Q15[idx];
      return val;
   endfunction

   // Quadrant of a heading in 0..359
   function automatic logic [QUAD_W-1:0] quadrant_of(input logic [ANGLE_W-1:0] h);
      logic [QUAD_W-1:0] q;
      if (h <= RIGHT_ANGLE)        q = QUAD_1;
      else if (h <= HALF_TURN)     q = QUAD_2;
      else if (h <= THREE_QUARTER) q = QUAD_3;
      else                         q = QUAD_4;
      return q;
   endfunction

endpackage

[rtl/drpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module drpt_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 1,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // Read port, old data on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/drpt_head.sv]
// Heading stage: turn update, quadrant fold and sine/cosine table lookup.
// Depends on drpt_pkg.
module drpt_head #(
   parameter  int SINE_FRAC_BITS = drpt_pkg::SINE_FRAC_DEF,
   localparam int SIN_W          = SINE_FRAC_BITS + 1
) (
   input  logic [drpt_pkg::FUNC_W-1:0]  func,
   input  logic [drpt_pkg::ANGLE_W-1:0] turn,
   input  drpt_pkg::head_type           cur,
   output drpt_pkg::head_type           nxt,
   output logic [SIN_W-1:0]             sin_a,
   output logic [SIN_W-1:0]             cos_a,
   output drpt_pkg::step_type           step
);
   import drpt_pkg::*;

   localparam int SINE_DN  = (SINE_FRAC_BITS < ROM_FRAC_BITS) ?
                             ROM_FRAC_BITS - SINE_FRAC_BITS : 0;
   localparam int SINE_UP  = (SINE_FRAC_BITS > ROM_FRAC_BITS) ?
                             SINE_FRAC_BITS - ROM_FRAC_BITS : 0;
   localparam int SINE_RND = (1 << SINE_DN) >> 1;

   // Rescale a table entry to the working fraction width
   function automatic logic [SIN_W-1:0] scale_sine(input logic [ROM_W-1:0] t);
      logic [ROM_W+1:0] v;
      v = (({2'b00, t} + (ROM_W+2)'(SINE_RND)) >> SINE_DN) << SINE_UP;
      return SIN_W'(v);
   endfunction

   logic [ANGLE_W-1:0]   ang;
   logic [ROM_IDX_W-1:0] a_idx;
   logic [ROM_IDX_W-1:0] c_idx;
   logic                 neg_x;
   logic                 neg_y;
   logic [ANGLE_W:0]     cw_diff;
   logic [ANGLE_W:0]     ccw_sum;
   logic [ANGLE_W-1:0]   new_heading;

   // Fold heading into a first-quadrant angle
   always_comb begin
      neg_x = 1'b0;
      neg_y = 1'b0;
      case (cur.quadrant)
         QUAD_1: begin
            ang = cur.heading;
         end
         QUAD_2: begin
            ang   = HALF_TURN - cur.heading;
            neg_x = 1'b1;
         end
         QUAD_3: begin
            ang   = cur.heading - HALF_TURN;
            neg_x = 1'b1;
            neg_y = 1'b1;
         end
         default: begin
            ang   = FULL_TURN - cur.heading;
            neg_y = 1'b1;
         end
      endcase
      a_idx = (ang > RIGHT_ANGLE) ? ROM_IDX_W'(RIGHT_ANGLE) : ang[ROM_IDX_W-1:0];
      c_idx = ROM_IDX_W'(RIGHT_ANGLE) - a_idx;
   end

   assign sin_a = scale_sine(sine_q15(a_idx));
   assign cos_a = scale_sine(sine_q15(c_idx));

   assign step.move  = (func == FUNC_MOVE);
   assign step.neg_x = neg_x;
   assign step.neg_y = neg_y;

   // Turn update with a single wrap into 0..359
   assign cw_diff = {1'b0, cur.heading} - {1'b0, turn};
   assign ccw_sum = {1'b0, cur.heading} + {1'b0, turn};

   always_comb begin
      nxt         = cur;
      new_heading = cur.heading;
      case (func)
         FUNC_TURN_CW: begin
            new_heading = cw_diff[ANGLE_W] ?
                          ANGLE_W'(cw_diff + (ANGLE_W+1)'(FULL_TURN)) :
                          cw_diff[ANGLE_W-1:0];
            nxt.prev_heading = cur.heading;
            nxt.heading      = new_heading;
            nxt.quadrant     = quadrant_of(new_heading);
         end
         FUNC_TURN_CCW: begin
            new_heading = (ccw_sum >= (ANGLE_W+1)'(FULL_TURN)) ?
                          ANGLE_W'(ccw_sum - (ANGLE_W+1)'(FULL_TURN)) :
                          ccw_sum[ANGLE_W-1:0];
            nxt.prev_heading = cur.heading;
            nxt.heading      = new_heading;
            nxt.quadrant     = quadrant_of(new_heading);
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

[rtl/drpt_acc.sv]
// Multiply stage and position accumulator with rounding and saturation.
// Depends on drpt_pkg.
module drpt_acc #(
   parameter  int POS_BITS       = drpt_pkg::POS_BITS_DEF,
   parameter  int DIST_BITS      = drpt_pkg::DIST_BITS_DEF,
   parameter  int SINE_FRAC_BITS = drpt_pkg::SINE_FRAC_DEF,
   localparam int SIN_W          = SINE_FRAC_BITS + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [DIST_BITS-1:0] in_dist,
   input  logic [SIN_W-1:0]           in_sin,
   input  logic [SIN_W-1:0]           in_cos,
   input  drpt_pkg::step_type         in_step,
   input  drpt_pkg::head_type         in_head,
   input  logic                       in_stale,
   input  logic signed [POS_BITS-1:0] in_mem_x,
   input  logic signed [POS_BITS-1:0] in_mem_y,
   input  logic signed [POS_BITS-1:0] wb_x,
   input  logic signed [POS_BITS-1:0] wb_y,
   input  logic                       out_ready,
   output drpt_pkg::fwd_type          fwd,
   output logic                       wr_en,
   output logic signed [POS_BITS-1:0] wr_x,
   output logic signed [POS_BITS-1:0] wr_y,
   output drpt_pkg::head_type         wr_head
);
   import drpt_pkg::*;

   localparam int PROD_W  = DIST_BITS + SIN_W + 1;
   localparam int DELTA_W = PROD_W + 1 - SINE_FRAC_BITS;
   localparam int SUM_W   = ((POS_BITS > DELTA_W) ? POS_BITS : DELTA_W) + 2;
   localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (SINE_FRAC_BITS - 1);

   // Round half away from zero, add or subtract, saturate
   function automatic logic signed [POS_BITS-1:0] step_pos(
      input logic signed [POS_BITS-1:0] base,
      input logic signed [PROD_W-1:0]   prod,
      input logic                       neg,
      input logic                       move
   );
      logic [PROD_W:0]           mag;
      logic [DELTA_W-1:0]        rmag;
      logic                      sub;
      logic signed [SUM_W-1:0]   delta;
      logic signed [SUM_W-1:0]   sum;
      logic signed [POS_BITS-1:0] res;
      mag   = {1'b0, (prod[PROD_W-1] ? -prod : prod)};
      rmag  = DELTA_W'((mag + HALF) >> SINE_FRAC_BITS);
      sub   = prod[PROD_W-1] ^ neg;
      delta = sub ? -$signed(SUM_W'(rmag)) : $signed(SUM_W'(rmag));
      sum   = SUM_W'(base) + delta;
      if (!move)
         res = base;
      else if ((sum[SUM_W-1:POS_BITS-1] == '0) || (sum[SUM_W-1:POS_BITS-1] == '1))
         res = sum[POS_BITS-1:0];
      else if (sum[SUM_W-1])
         res = {1'b1, {(POS_BITS-1){1'b0}}};
      else
         res = {1'b0, {(POS_BITS-1){1'b1}}};
      return res;
   endfunction

   logic                       valid_ff, valid_in;
   logic signed [PROD_W-1:0]   prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0]   prod_y_ff, prod_y_in;
   step_type                   step_ff, step_in;
   head_type                   head_ff, head_in;
   logic                       stale_ff, stale_in;
   logic signed [POS_BITS-1:0] mem_x_ff, mem_x_in;
   logic signed [POS_BITS-1:0] mem_y_ff, mem_y_in;
   logic                       load;
   logic signed [PROD_W-1:0]   dist_ext;
   logic signed [PROD_W-1:0]   sin_ext;
   logic signed [PROD_W-1:0]   cos_ext;
   logic signed [POS_BITS-1:0] base_x;
   logic signed [POS_BITS-1:0] base_y;

   // Stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign wr_en    = valid_ff && out_ready;
   assign valid_in = load ? 1'b1 : (wr_en ? 1'b0 : valid_ff);

   // Signed distance times unsigned sine
   assign dist_ext  = PROD_W'(in_dist);
   assign sin_ext   = $signed(PROD_W'(in_sin));
   assign cos_ext   = $signed(PROD_W'(in_cos));
   assign prod_x_in = load ? PROD_W'(dist_ext * cos_ext) : prod_x_ff;
   assign prod_y_in = load ? PROD_W'(dist_ext * sin_ext) : prod_y_ff;
   assign step_in   = load ? in_step  : step_ff;
   assign head_in   = load ? in_head  : head_ff;
   assign stale_in  = load ? in_stale : stale_ff;
   assign mem_x_in  = load ? in_mem_x : mem_x_ff;
   assign mem_y_in  = load ? in_mem_y : mem_y_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      step_ff   <= step_in;
      head_ff   <= head_in;
      stale_ff  <= stale_in;
      mem_x_ff  <= mem_x_in;
      mem_y_ff  <= mem_y_in;
   end

   // Position base: last write-back when the memory read went stale
   assign base_x = stale_ff ? wb_x : mem_x_ff;
   assign base_y = stale_ff ? wb_y : mem_y_ff;

   assign wr_x    = step_pos(base_x, prod_x_ff, step_ff.neg_x, step_ff.move);
   assign wr_y    = step_pos(base_y, prod_y_ff, step_ff.neg_y, step_ff.move);
   assign wr_head = head_ff;

   assign fwd.valid = valid_ff;
   assign fwd.head  = head_ff;

endmodule

[rtl/dead_reckoning_pose_tracker.sv]
// Top level of the planar pose tracker: input stage, pose memory, output register.
// Depends on drpt_pkg, drpt_ram, drpt_head, drpt_acc and the assertion macros.
//
//   channel | direction | tdata (low bit up)                                | tuser
//   req_    | in        | distance_mm, turn_degrees                         | func
//   rsp_    | out       | pos_x, pos_y, heading, prev_heading, quadrant     | -
//
// From an input transfer to the result register, the input stage registers the
// command and pose memory read, the multiply stage the heading update, sine lookup
// and multiply, and the result register the rounding, position add and saturation.
// One item per cycle is sustained while the result side is ready; position add,
// heading update and pose write-back keep up by forwarding from items in flight.
// Synchronous reset clears the pose to origin, heading 0, quadrant 1; no clear pass.
// A stalled result holds the pipeline; the two stages still fill behind it.
`include "dead_reckoning_pose_tracker_macros.svh"

module dead_reckoning_pose_tracker #(
   parameter  int POS_BITS       = drpt_pkg::POS_BITS_DEF,
   parameter  int DIST_BITS      = drpt_pkg::DIST_BITS_DEF,
   parameter  int SINE_FRAC_BITS = drpt_pkg::SINE_FRAC_DEF,
   localparam int REQ_DATA_W     = ((DIST_BITS + drpt_pkg::ANGLE_W + 7) / 8) * 8,
   localparam int RSP_DATA_W     = ((2 * POS_BITS + 2 * drpt_pkg::ANGLE_W
                                     + drpt_pkg::QUAD_W + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_DATA_W-1:0]        req_tdata,  // distance_mm, turn_degrees
   input  logic [drpt_pkg::FUNC_W-1:0]  req_tuser,  // func
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_DATA_W-1:0]        rsp_tdata   // pos_x, pos_y, heading,
                                                    // prev_heading, quadrant
);
   import drpt_pkg::*;

   localparam int SIN_W   = SINE_FRAC_BITS + 1;
   localparam int STATE_W = 2 * POS_BITS + $bits(head_type);
   localparam int MEM_DEPTH = 1;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   logic                       req_xfer;
   logic [ANGLE_W-1:0]         turn_raw;
   logic [ANGLE_W-1:0]         turn_red;

   // Input stage
   logic                       b_valid_ff, b_valid_in;
   logic [FUNC_W-1:0]          b_func_ff, b_func_in;
   logic signed [DIST_BITS-1:0] b_dist_ff, b_dist_in;
   logic [ANGLE_W-1:0]         b_turn_ff, b_turn_in;
   logic                       b_stale_ff, b_stale_in;
   logic                       b_adv;

   // Pose memory and write-back copy
   logic                       mem_init_ff, mem_init_in;
   logic [STATE_W-1:0]         rd_data;
   logic signed [POS_BITS-1:0] rd_x;
   logic signed [POS_BITS-1:0] rd_y;
   head_type                   rd_head;
   logic signed [POS_BITS-1:0] wb_x_ff, wb_x_in;
   logic signed [POS_BITS-1:0] wb_y_ff, wb_y_in;
   head_type                   wb_head_ff, wb_head_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_ready;

   // Between stages
   head_type                   cur_head;
   head_type                   nxt_head;
   logic [SIN_W-1:0]           sin_a;
   logic [SIN_W-1:0]           cos_a;
   step_type                   step;
   logic                       m_ready;
   fwd_type                    m_fwd;
   logic                       wr_en;
   logic signed [POS_BITS-1:0] wr_x;
   logic signed [POS_BITS-1:0] wr_y;
   head_type                   wr_head;

   // Input transfer and turn pre-reduction
   assign req_xfer   = req_tvalid && req_tready;
   assign req_tready = !b_valid_ff || m_ready;
   assign b_adv      = b_valid_ff && m_ready;
   assign turn_raw   = req_tdata[DIST_BITS +: ANGLE_W];
   assign turn_red   = (turn_raw >= FULL_TURN) ? turn_raw - FULL_TURN : turn_raw;

   // Read is stale if anything older is in flight or memory is unwritten
   assign b_valid_in = req_xfer ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
   assign b_func_in  = req_xfer ? req_tuser : b_func_ff;
   assign b_dist_in  = req_xfer ? $signed(req_tdata[DIST_BITS-1:0]) : b_dist_ff;
   assign b_turn_in  = req_xfer ? turn_red : b_turn_ff;
   assign b_stale_in = req_xfer ? (b_valid_ff || m_fwd.valid || !mem_init_ff) : b_stale_ff;

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else       b_valid_ff <= b_valid_in;
   end

   always_ff @(posedge clock) begin
      b_func_ff  <= b_func_in;
      b_dist_ff  <= b_dist_in;
      b_turn_ff  <= b_turn_in;
      b_stale_ff <= b_stale_in;
   end

   // Pose memory: read on transfer, written by the accumulator
   drpt_ram #(
      .WIDTH (STATE_W),
      .DEPTH (MEM_DEPTH)
   ) u_pose_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (MEM_AW'(0)),
      .wr_data ({wr_head, wr_y, wr_x}),
      .rd_en   (req_xfer),
      .rd_addr (MEM_AW'(0)),
      .rd_data (rd_data)
   );

   assign rd_x    = rd_data[POS_BITS-1:0];
   assign rd_y    = rd_data[2*POS_BITS-1:POS_BITS];
   assign rd_head = head_type'(rd_data[STATE_W-1:2*POS_BITS]);

   // Heading source: item in multiply stage, else last write, else memory
   assign cur_head = m_fwd.valid ? m_fwd.head : (b_stale_ff ? wb_head_ff : rd_head);

   drpt_head #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_head (
      .func  (b_func_ff),
      .turn  (b_turn_ff),
      .cur   (cur_head),
      .nxt   (nxt_head),
      .sin_a (sin_a),
      .cos_a (cos_a),
      .step  (step)
   );

   drpt_acc #(
      .POS_BITS       (POS_BITS),
      .DIST_BITS      (DIST_BITS),
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_ready  (m_ready),
      .in_dist   (b_dist_ff),
      .in_sin    (sin_a),
      .in_cos    (cos_a),
      .in_step   (step),
      .in_head   (nxt_head),
      .in_stale  (b_stale_ff),
      .in_mem_x  (rd_x),
      .in_mem_y  (rd_y),
      .wb_x      (wb_x_ff),
      .wb_y      (wb_y_ff),
      .out_ready (out_ready),
      .fwd       (m_fwd),
      .wr_en     (wr_en),
      .wr_x      (wr_x),
      .wr_y      (wr_y),
      .wr_head   (wr_head)
   );

   // Write-back copy doubles as the result payload
   assign mem_init_in  = mem_init_ff || wr_en;
   assign wb_x_in      = wr_en ? wr_x : wb_x_ff;
   assign wb_y_in      = wr_en ? wr_y : wb_y_ff;
   assign wb_head_in   = wr_en ? wr_head : wb_head_ff;
   assign out_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = wr_en ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_init_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wb_x_ff      <= '0;
         wb_y_ff      <= '0;
         wb_head_ff   <= '{quadrant: QUAD_1, prev_heading: '0, heading: '0};
      end else begin
         mem_init_ff  <= mem_init_in;
         rsp_valid_ff <= rsp_valid_in;
         wb_x_ff      <= wb_x_in;
         wb_y_ff      <= wb_y_in;
         wb_head_ff   <= wb_head_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({wb_head_ff, wb_y_ff, wb_x_ff});

   // Checks
   `DRPT_ASSERT_ALWAYS(a_head_range, clock, reset, wb_head_ff.heading < FULL_TURN,
      "heading out of range")
   `DRPT_ASSERT_ALWAYS(a_quad_match, clock, reset,
      wb_head_ff.quadrant == quadrant_of(wb_head_ff.heading),
      "quadrant does not match heading")
   `DRPT_ASSERT_NEXT(a_rsp_after_wr, clock, reset, wr_en, rsp_valid_ff,
      "write-back without result")
   `DRPT_ASSERT_IMPLY(a_b_stall, clock, reset, b_valid_ff && !b_adv,
      m_fwd.valid && !wr_en, "input stage stalled with free multiply stage")

endmodule

[test/tb.sv]
// Self-checking bench for the planar pose tracker: drives move, turn and unused
// commands, predicts the pose after each one and compares every result field by field.
// Depends on drpt_pkg and dead_reckoning_pose_tracker from the rtl folder.
`timescale 1ns / 100ps

module tb;
   import drpt_pkg::*;

   // Code the block leaves unused; it must report the pose unchanged
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   localparam int ITEM_TOTAL = 1650;
   localparam int IDLE_PCT   = 38;
   localparam int HOLD_LEN   = 160;

   // Result layout, pos_x in the lowest bits
   typedef struct packed {
      logic [2:0]         pad;
      logic [QUAD_W-1:0]  quadrant;
      logic [ANGLE_W-1:0] prev_heading;
      logic [ANGLE_W-1:0] heading;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_x;
   } pose_type;

   // Pose predictor and the queue of poses still to come out
   class pose_checker;
      int   pos_x = 0;
      int   pos_y = 0;
      int   heading = 0;
      int   prev_heading = 0;
      int   quadrant = QUAD_1;
      pose_type pose_due[$];
      int   mismatches = 0;
      int   checked = 0;
      int   moves = 0;
      int   turns = 0;
      int   spares = 0;
      int   clamps = 0;

      function int pending();
         return pose_due.size();
      endfunction

      function int quad_for_heading(int h);
         if (h <= 90)  return QUAD_1;
         if (h <= 180) return QUAD_2;
         if (h <= 270) return QUAD_3;
         return QUAD_4;
      endfunction

      // distance times Q1.15 sine, rounded half away from zero
      function int round_scaled(int d, int s);
         int p;
         int mag;
         p   = d * s;
         mag = (p < 0) ? -p : p;
         mag = (mag + (1 << 14)) >>> 15;
         return (p < 0) ? -mag : mag;
      endfunction

      function int clamp_pos(int v);
         if (v > 32767) begin
            clamps++;
            return 32767;
         end
         if (v < -32768) begin
            clamps++;
            return -32768;
         end
         return v;
      endfunction

      // Apply one accepted command and queue the pose it leaves behind
      function void log_motion(logic [FUNC_W-1:0] f, logic signed [11:0] d,
                               logic [ANGLE_W-1:0] t);
         int       a;
         int       dx;
         int       dy;
         int       nh;
         int       turn;
         bit       neg_x;
         bit       neg_y;
         pose_type p;
         turn  = t;
         if (turn >= 360) turn -= 360;
         neg_x = 0;
         neg_y = 0;
         case (f)
            FUNC_MOVE: begin
               moves++;
               // fold heading into the first quadrant
               case (quadrant)
                  QUAD_1: a = heading;
                  QUAD_2: begin
                     a = 180 - heading;
                     neg_x = 1;
                  end
                  QUAD_3: begin
                     a = heading - 180;
                     neg_x = 1;
                     neg_y = 1;
                  end
                  default: begin
                     a = 360 - heading;
                     neg_y = 1;
                  end
               endcase
               if (a > 90) a = 90;
               dx = round_scaled(int'(d), int'(SINE_Q15[90 - a]));
               dy = round_scaled(int'(d), int'(SINE_Q15[a]));
               pos_x = clamp_pos(neg_x ? pos_x - dx : pos_x + dx);
               pos_y = clamp_pos(neg_y ? pos_y - dy : pos_y + dy);
            end
            FUNC_TURN_CW: begin
               turns++;
               nh = heading - turn;
               if (nh < 0) nh += 360;
               prev_heading = heading;
               heading      = nh;
               quadrant     = quad_for_heading(heading);
            end
            FUNC_TURN_CCW: begin
               turns++;
               nh = heading + turn;
               if (nh >= 360) nh -= 360;
               prev_heading = heading;
               heading      = nh;
               quadrant     = quad_for_heading(heading);
            end
            default: spares++;
         endcase
         p.pad          = '0;
         p.quadrant     = quadrant[QUAD_W-1:0];
         p.prev_heading = prev_heading[ANGLE_W-1:0];
         p.heading      = heading[ANGLE_W-1:0];
         p.pos_y        = pos_y[15:0];
         p.pos_x        = pos_x[15:0];
         pose_due.push_back(p);
      endfunction

      function void flag(string what, int want, int got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                     $realtime, what, checked, want, got);
      endfunction

      // Compare one result transfer against the oldest predicted pose
      function void match_pose(logic [55:0] data);
         pose_type got;
         pose_type want;
         got = data;
         if (pose_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no command pending: %h", $realtime, data);
            return;
         end
         want = pose_due.pop_front();
         if (got.pos_x != want.pos_x)
            flag("pos_x", int'(want.pos_x), int'(got.pos_x));
         if (got.pos_y != want.pos_y)
            flag("pos_y", int'(want.pos_y), int'(got.pos_y));
         if (got.heading != want.heading)
            flag("heading", int'(want.heading), int'(got.heading));
         if (got.prev_heading != want.prev_heading)
            flag("prev_heading", int'(want.prev_heading), int'(got.prev_heading));
         if (got.quadrant != want.quadrant)
            flag("quadrant", int'(want.quadrant), int'(got.quadrant));
         if (got.pad != want.pad)
            flag("padding", int'(want.pad), int'(got.pad));
         checked++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;        // distance_mm, turn_degrees
   logic [1:0]  req_tuser = '0;        // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;             // pos_x, pos_y, heading, prev_heading, quadrant

   pose_checker sb;
   bit          steady = 0;            // no idling on either side while set
   bit          hold_rsp = 0;          // asks the receiver for a long hold-off
   int          items_sent = 0;

   dead_reckoning_pose_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: random back-pressure, plus one long hold-off on request
   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            held = 0;
            while (held < HOLD_LEN) begin
               @(negedge clock);
               held++;
            end
            hold_rsp = 0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.match_pose(rsp_tdata);
   end

   // Offer one command and hold it until the block takes it
   task automatic push_cmd(logic [FUNC_W-1:0] f, logic [11:0] d, logic [ANGLE_W-1:0] t);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {3'b000, t, d};
      do @(posedge clock); while (!req_tready);
      sb.log_motion(f, d, t);
      items_sent++;
   endtask

   task automatic move(int d);
      push_cmd(FUNC_MOVE, d[11:0], ANGLE_W'($urandom_range(0, 511)));
   endtask

   task automatic turn(logic [FUNC_W-1:0] f, int t);
      push_cmd(f, 12'($urandom_range(0, 4095)), t[ANGLE_W-1:0]);
   endtask

   // Stop offering and wait for every pending pose to come out
   task automatic drain();
      int guard;
      @(negedge clock);
      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // Maybe a turn, then a run of long moves in one direction to push toward the limits
   task automatic drive_leg();
      int n;
      bit back;
      if ($urandom_range(0, 1))
         turn($urandom_range(0, 1) ? FUNC_TURN_CW : FUNC_TURN_CCW, $urandom_range(0, 511));
      n    = $urandom_range(3, 24);
      back = $urandom_range(0, 1);
      repeat (n) begin
         if (back) move(-$urandom_range(1200, 2048));
         else      move($urandom_range(1200, 2047));
      end
   endtask

   task automatic random_cmd();
      push_cmd(FUNC_W'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
               ANGLE_W'($urandom_range(0, 511)));
   endtask

   initial begin
      #4_000_000;
      $display("Timeout: results stopped arriving");
      $display("** dead_reckoning_pose_tracker: FAILED **");
      $finish;
   end

   initial begin
      bit held_once;
      bit paused_once;
      sb = new;
      held_once   = 0;
      paused_once = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, rounding, every quadrant edge, angle wrap
      move(2047);
      move(-2048);
      move(1);
      move(-1);
      move(0);
      turn(FUNC_TURN_CCW, 90);
      move(1000);
      turn(FUNC_TURN_CCW, 45);
      move(-1500);
      turn(FUNC_TURN_CCW, 45);
      move(777);
      turn(FUNC_TURN_CCW, 90);
      move(2047);
      turn(FUNC_TURN_CCW, 1);
      move(-2048);
      turn(FUNC_TURN_CW, 360);      // full turn keeps heading, copies it to prev
      turn(FUNC_TURN_CW, 511);      // above 359, reduced first
      turn(FUNC_TURN_CCW, 511);
      turn(FUNC_TURN_CW, 0);
      push_cmd(FUNC_SPARE, 12'hFFF, 9'h1FF);
      turn(FUNC_TURN_CW, 300);      // wraps below zero
      turn(FUNC_TURN_CCW, 359);     // wraps past 359
      move(3);

      // Random: mostly long legs that reach saturation, the rest anything
      while (items_sent < ITEM_TOTAL) begin
         if (!held_once && items_sent > 300) begin
            held_once = 1;
            hold_rsp  = 1;
         end
         if (!paused_once && items_sent > 800) begin
            paused_once = 1;
            drain();
         end
         steady = (items_sent >= 1000 && items_sent < 1250);
         if ($urandom_range(0, 99) < 55) drive_leg();
         else                            random_cmd();
      end
      steady = 0;

      drain();
      repeat (16) @(posedge clock);
      $display("Covered %0d moves, %0d turns, %0d unused codes; %0d results checked",
               sb.moves, sb.turns, sb.spares, sb.checked);
      $display("Position clamped %0d times; %0d mismatches, %0d results missing",
               sb.clamps, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** dead_reckoning_pose_tracker: PASSED **");
      end else begin
         $display("** dead_reckoning_pose_tracker: FAILED **");
      end
      $finish;
   end

endmodule
